>>> src/assert_macros.svh
// Assertion macros shared by the parser RTL.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("%m: implication failed");
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("%m: next-cycle property failed");
`else
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

>>> src/ipv4dd_pkg.sv
// Types and constants for the dotted-decimal IPv4 parser.
// No dependencies; used by the stage modules and the top level.
`default_nettype none
package ipv4dd_pkg;
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SYNTAX = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;
	localparam logic [1:0] ST_TRUNC  = 2'd3;

	localparam logic [7:0] CHAR_DOT  = 8'h2E;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam logic [9:0] OCTET_MAX   = 10'd255;
	localparam logic [3:0] OFFSET_MAX  = 4'd15;
	localparam int         MIN_OK_LEN  = 7;

	typedef struct packed {
		logic [7:0] char_in;
		logic       start_req;
		logic       at_end;
	} item_t;

	typedef struct packed {
		logic        valid;
		item_t       item;
	} item_beat_t;

	typedef struct packed {
		logic [31:0] address;
		logic [1:0]  status;
		logic [3:0]  error_offset;
		logic [3:0]  consumed;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} res_beat_t;
endpackage
`default_nettype wire

>>> src/ipv4dd_in_if.sv
// Character channel of the parser: valid/ready handshake with one character per beat.
// Stands alone; no package needed.
`default_nettype none
interface ipv4dd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       start_req;
	logic       at_end;

	modport source (output valid, output char_in, output start_req, output at_end,
		input ready);
	modport sink (input valid, input char_in, input start_req, input at_end,
		output ready);
endinterface
`default_nettype wire

>>> src/ipv4dd_out_if.sv
// Result channel of the parser: valid/ready handshake with one parsed address per beat.
// Stands alone; no package needed.
`default_nettype none
interface ipv4dd_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] address;
	logic [1:0]  status;
	logic [3:0]  error_offset;
	logic [3:0]  consumed;

	modport source (output valid, output address, output status, output error_offset,
		output consumed, input ready);
	modport sink (input valid, input address, input status, input error_offset,
		input consumed, output ready);
endinterface
`default_nettype wire

>>> src/ipv4dd_in_reg.sv
// Input register stage: captures one character beat whenever the stage is free or draining.
// Depends on ipv4dd_pkg.
`default_nettype none
module ipv4dd_in_reg import ipv4dd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire item_t      in_item,
	output logic            in_ready,
	input  wire logic       advance,
	output item_beat_t      beat_s1
);
	logic  valid_s1;
	item_t item_s1;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	assign beat_s1 = '{valid: valid_s1, item: item_s1};
endmodule
`default_nettype wire

>>> src/ipv4dd_core.sv
// Parse state and the per-character step logic of the dotted-decimal parser.
// Depends on ipv4dd_pkg.
`default_nettype none
module ipv4dd_core import ipv4dd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire item_beat_t beat_s1,
	input  wire logic       advance,
	output res_beat_t       step_res
);
	logic        busy_q;
	logic [1:0]  octet_index_q;
	logic [1:0]  digit_count_q;
	logic [9:0]  octet_value_q;
	logic        expect_dot_q;
	logic [23:0] collected_q;
	logic [3:0]  offset_q;
	logic [3:0]  octet_start_q;

	logic        busy_n;
	logic [1:0]  octet_index_n;
	logic [1:0]  digit_count_n;
	logic [9:0]  octet_value_n;
	logic        expect_dot_n;
	logic [23:0] collected_n;
	logic [3:0]  offset_n;
	logic [3:0]  octet_start_n;

	logic        fire;
	logic        is_digit;
	logic        is_dot;
	logic [3:0]  digit;
	logic [7:0]  digit_wide;
	logic [9:0]  times_ten;
	logic [3:0]  offset_inc;
	res_beat_t   res;

	assign fire       = beat_s1.valid && advance;
	assign digit_wide = beat_s1.item.char_in - CHAR_ZERO;

	always_comb begin
		is_digit = beat_s1.item.char_in inside {[CHAR_ZERO:CHAR_NINE]};
		is_dot   = (beat_s1.item.char_in == CHAR_DOT);
		digit    = digit_wide[3:0];
	end

	always_comb begin
		busy_n        = busy_q;
		octet_index_n = octet_index_q;
		digit_count_n = digit_count_q;
		octet_value_n = octet_value_q;
		expect_dot_n  = expect_dot_q;
		collected_n   = collected_q;
		offset_n      = offset_q;
		octet_start_n = octet_start_q;
		res           = '0;
		if (beat_s1.item.start_req) begin
			busy_n        = 1'b1;
			octet_index_n = 2'd0;
			digit_count_n = 2'd0;
			octet_value_n = 10'd0;
			expect_dot_n  = 1'b0;
			collected_n   = 24'd0;
			offset_n      = 4'd0;
			octet_start_n = 4'd0;
		end
		offset_inc = (offset_n == OFFSET_MAX) ? offset_n : offset_n + 4'd1;
		times_ten  = {octet_value_n[6:0], 3'b000} + {octet_value_n[8:0], 1'b0}
			+ {6'd0, digit};
		if (busy_n) begin
			if (digit_count_n == 2'd0) begin
				octet_start_n = offset_n;
				if (beat_s1.item.at_end) begin
					res.valid = 1'b1;
					res.res.status = ST_TRUNC;
					res.res.error_offset = offset_n;
				end else if (!is_digit) begin
					res.valid = 1'b1;
					res.res.status = ST_SYNTAX;
					res.res.error_offset = offset_n;
				end else begin
					octet_value_n = {6'd0, digit};
					digit_count_n = 2'd1;
					expect_dot_n  = (digit == 4'd0);
					offset_n      = offset_inc;
				end
			end else if (beat_s1.item.at_end) begin
				res.valid = 1'b1;
				if (octet_value_n > OCTET_MAX) begin
					res.res.status = ST_RANGE;
					res.res.error_offset = octet_start_n;
				end else begin
					res.res.status = ST_TRUNC;
					res.res.error_offset = offset_n;
				end
			end else if (is_digit) begin
				if (expect_dot_n) begin
					res.valid = 1'b1;
					res.res.status = ST_SYNTAX;
					res.res.error_offset = offset_n;
				end else begin
					octet_value_n = times_ten;
					digit_count_n = digit_count_n + 2'd1;
					if (digit_count_n == 2'd3) begin
						expect_dot_n = 1'b1;
					end
					offset_n = offset_inc;
				end
			end else if (octet_value_n > OCTET_MAX) begin
				res.valid = 1'b1;
				res.res.status = ST_RANGE;
				res.res.error_offset = octet_start_n;
			end else if (octet_index_n != 2'd3) begin
				if (!is_dot) begin
					res.valid = 1'b1;
					res.res.status = ST_SYNTAX;
					res.res.error_offset = offset_n;
				end else begin
					collected_n   = {collected_n[15:0], octet_value_n[7:0]};
					octet_index_n = octet_index_n + 2'd1;
					digit_count_n = 2'd0;
					octet_value_n = 10'd0;
					expect_dot_n  = 1'b0;
					offset_n      = offset_inc;
				end
			end else if (is_dot) begin
				res.valid = 1'b1;
				res.res.status = ST_SYNTAX;
				res.res.error_offset = offset_n;
			end else begin
				res.valid = 1'b1;
				res.res.status = ST_OK;
				res.res.address = {collected_n, octet_value_n[7:0]};
				res.res.consumed = offset_n;
			end
			if (res.valid) begin
				busy_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			octet_index_q <= 2'd0;
			digit_count_q <= 2'd0;
			octet_value_q <= 10'd0;
			expect_dot_q  <= 1'b0;
			collected_q   <= 24'd0;
			offset_q      <= 4'd0;
			octet_start_q <= 4'd0;
		end else if (fire) begin
			busy_q        <= busy_n;
			octet_index_q <= octet_index_n;
			digit_count_q <= digit_count_n;
			octet_value_q <= octet_value_n;
			expect_dot_q  <= expect_dot_n;
			collected_q   <= collected_n;
			offset_q      <= offset_n;
			octet_start_q <= octet_start_n;
		end
	end

	assign step_res = '{valid: fire && res.valid, res: res.res};
endmodule
`default_nettype wire

>>> src/ipv4dd_out_reg.sv
// Result register: holds one finished parse result until the downstream side takes it.
// Depends on ipv4dd_pkg.
`default_nettype none
module ipv4dd_out_reg import ipv4dd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire res_beat_t step_res,
	input  wire logic      out_ready,
	output logic           advance,
	output res_beat_t      out_beat
);
	logic valid_q;
	res_t res_q;

	assign advance = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= step_res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.valid) begin
			res_q <= step_res.res;
		end
	end

	assign out_beat = '{valid: valid_q, res: res_q};
endmodule
`default_nettype wire

>>> src/ipv4_dotted_decimal_parser.sv
// Top level of the strict dotted-decimal IPv4 parser: input register, parse step, result register.
// Depends on ipv4dd_pkg, ipv4dd_in_if, ipv4dd_out_if, the three stage modules and assert_macros.svh.
//
//   Channel   Direction   Beat contents
//   chars     in          char_in[8], start_req, at_end
//   results   out         address[32], status[2], error_offset[4], consumed[4]
//
// One character is accepted per cycle unless a stalled result holds a full input register.
// The result of the beat that finishes the address is registered in the result register;
// the per-character step is combinational logic between the input and result registers.
// Reset clears the parse state and both valids. A stalled result holds the input register.
`default_nettype none
`include "assert_macros.svh"
module ipv4_dotted_decimal_parser import ipv4dd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ipv4dd_in_if.sink   chars,
	ipv4dd_out_if.source results
);
	item_t      in_item;
	item_beat_t beat_s1;
	res_beat_t  step_res;
	res_beat_t  out_beat;
	logic       advance;

	assign in_item = '{char_in: chars.char_in, start_req: chars.start_req,
		at_end: chars.at_end};

	ipv4dd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chars.valid),
		.in_item  (in_item),
		.in_ready (chars.ready),
		.advance  (advance),
		.beat_s1  (beat_s1)
	);

	ipv4dd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.beat_s1  (beat_s1),
		.advance  (advance),
		.step_res (step_res)
	);

	ipv4dd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_res  (step_res),
		.out_ready (results.ready),
		.advance   (advance),
		.out_beat  (out_beat)
	);

	assign results.valid        = out_beat.valid;
	assign results.address      = out_beat.res.address;
	assign results.status       = out_beat.res.status;
	assign results.error_offset = out_beat.res.error_offset;
	assign results.consumed     = out_beat.res.consumed;

	`ASSERT_IMPLIES(a_ok_fields, clk, arst_n, results.valid && results.status == ST_OK, results.error_offset == 4'd0 && results.consumed >= 4'(MIN_OK_LEN))
	`ASSERT_IMPLIES(a_err_fields, clk, arst_n, results.valid && results.status != ST_OK, results.address == 32'd0 && results.consumed == 4'd0)
	`ASSERT_IMPLIES(a_stall_path, clk, arst_n, !chars.ready, results.valid && !results.ready)
	`ASSERT_NEXT(a_result_source, clk, arst_n, !beat_s1.valid && !results.valid, !results.valid)
endmodule
`default_nettype wire
